// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== src/mdbp_pkg.sv =====
package mdbp_pkg;

    localparam int MAX_BUCKETS      = 256;
    localparam int BKT_W            = $clog2(MAX_BUCKETS);
    localparam int MAX_ROW_ELEMENTS = 64;
    localparam int ROW_AW           = $clog2(MAX_ROW_ELEMENTS);
    localparam int MAX_ROWS         = 1048576;

    // operation selector on the input side
    typedef enum logic [1:0] {
        F_CLEAR = 2'd0,
        F_COUNT = 2'd1,
        F_PACK  = 2'd2,
        F_QUERY = 2'd3
    } t_func;

    // result kind
    localparam logic K_MEMBER = 1'b0;
    localparam logic K_COUNT  = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CI_ELEMS   = 3'd0,
        CI_RUN_LEN = 3'd1,
        CI_RUNS    = 3'd2,
        CI_SLOTS   = 3'd3,
        CI_NODES   = 3'd4,
        CI_EXPERTS = 3'd5,
        CI_ROWS    = 3'd6
    } t_cfg_idx;

    // effective configuration (zeros and overranges already folded)
    typedef struct packed {
        logic [6:0]  row_len;
        logic [6:0]  run_len;
        logic [6:0]  runs;
        logic [16:0] slots;
        logic [8:0]  nodes;
        logic [16:0] elim;
        logic [20:0] row_lim;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [16:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic        kind;
        logic [19:0] dest_row;
        logic [19:0] source_token;
        logic [5:0]  member_index;
        logic [15:0] slot;
        logic [31:0] gate_out;
        logic [20:0] node_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        vld;
        logic [31:0] gate;
        logic [31:0] id;
    } t_row_ent;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CNT_DIV,
        S_CNT_WR,
        S_QRY_RD,
        S_QRY_ST,
        S_QRY_DIV,
        S_QRY_OUT,
        S_CUR_RD,
        S_CUR_ST,
        S_CUR_DIV,
        S_STORE,
        S_SORT_RA,
        S_SORT_GA,
        S_SORT_CHK,
        S_SORT_CMP,
        S_RUN_CHK,
        S_RUN_LD,
        S_RUN_DIV,
        S_RUN_CUR,
        S_MEM_CHK,
        S_MEM_LD,
        S_MEM_DIV,
        S_MEM_OUT,
        S_DONE
    } t_state;

endpackage

// ===== src/mdbp_div.sv =====
module mdbp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdbp_pkg::t_div_req i_req,
    output mdbp_pkg::t_div_rsp o_rsp
);
    import mdbp_pkg::*;
    `include "assert_macros.svh"

    logic [31:0] r_quo;
    logic [16:0] r_rem;
    logic [16:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] shifted;
    logic        fits;

    // one quotient bit per cycle, restoring
    assign shifted = {r_rem, r_quo[31]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= fits ? 17'(shifted - {1'b0, r_dvs}) : shifted[16:0];
            r_quo <= {r_quo[30:0], fits};
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

    `ASSERT_ON_CLK(a_no_restart, i_clk, i_rst_n, i_req.start |-> !r_busy,
        "divider started while busy")
    `ASSERT_ON_CLK(a_busy_done_excl, i_clk, i_rst_n, !(r_busy && r_done),
        "divider busy and done together")

endmodule

// ===== src/mdbp_core.sv =====
module mdbp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mdbp_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mdbp_pkg::t_func    i_func,
    input  logic [31:0]        i_id,
    input  logic [31:0]        i_gate,
    input  logic [7:0]         i_node,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output mdbp_pkg::t_result  o_res,
    output mdbp_pkg::t_div_req o_div_req,
    input  mdbp_pkg::t_div_rsp i_div_rsp
);
    import mdbp_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;

    // memories
    logic [31:0] r_hist_mem [MAX_BUCKETS];
    logic [31:0] r_cur_mem  [MAX_BUCKETS];
    t_row_ent    r_row_mem  [MAX_ROW_ELEMENTS];
    logic [MAX_BUCKETS-1:0] r_hist_vld;

    logic [31:0] r_hist_rd, r_cur_rd;
    logic        r_hist_rv;
    t_row_ent    r_row_rd;

    logic             hist_we, cur_we, row_we;
    logic [BKT_W-1:0] hist_wa, hist_ra, cur_wa, cur_ra;
    logic [31:0]      hist_wd, cur_wd, hist_eff;
    logic [ROW_AW-1:0] row_wa, row_ra;
    t_row_ent         row_wd;

    // item and walk registers
    logic [31:0]       r_id, r_gate;
    logic [7:0]        r_node;
    logic              r_in_rng;
    logic [6:0]        r_elem;
    logic [19:0]       r_tok;
    logic              r_cur_ready;
    logic [31:0]       r_base;
    logic [BKT_W-1:0]  r_bkt;
    logic [6:0]        r_a;
    logic [ROW_AW-1:0] r_b;
    t_row_ent          r_ev;
    logic [6:0]        r_j;
    logic [7:0]        r_lead;
    logic [6:0]        r_i;
    logic [31:0]       r_dst;
    t_row_ent          r_ent;
    logic [15:0]       r_slot;
    logic [20:0]       r_cnt;
    t_result           r_pend;
    logic              r_pend_v;

    logic        in_rng, in_acc, out_free;
    logic [6:0]  elem_n, a_n;
    logic [8:0]  mem_pos;
    logic        mem_end, run_end, sort_gt, sort_next, run_adv;
    logic        div_node_bad, cur_over;
    t_result     new_res;

    assign in_rng   = !i_id[31] && (i_id < {15'd0, i_cfg.elim});
    assign in_acc   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_pend_v || i_res_ready;
    assign hist_eff = r_hist_rv ? r_hist_rd : 32'd0;
    assign elem_n   = r_elem + 7'd1;
    assign a_n      = r_a + 7'd1;
    assign mem_pos  = {1'b0, r_lead} + {2'd0, r_i};
    assign mem_end  = (r_i >= i_cfg.run_len) || (mem_pos >= {2'd0, i_cfg.row_len});
    assign run_end  = (r_j >= i_cfg.runs) || (r_lead >= {1'b0, i_cfg.row_len});
    assign sort_gt  = r_row_rd.id > r_ev.id;
    assign sort_next = ((r_state == S_SORT_CHK) && (r_b == '0)) ||
                       ((r_state == S_SORT_CMP) && !sort_gt);
    assign div_node_bad = i_div_rsp.quot >= {23'd0, i_cfg.nodes};
    assign cur_over = r_cur_rd >= {11'd0, i_cfg.row_lim};
    assign run_adv  = ((r_state == S_RUN_LD) && !r_row_rd.vld) ||
                      ((r_state == S_RUN_DIV) && i_div_rsp.done && div_node_bad) ||
                      ((r_state == S_RUN_CUR) && cur_over) ||
                      ((r_state == S_MEM_CHK) && mem_end);

    // member entry built from the current run state
    always_comb begin
        new_res              = '0;
        new_res.kind         = K_MEMBER;
        new_res.dest_row     = r_dst[19:0];
        new_res.source_token = r_tok;
        new_res.member_index = r_i[5:0];
        new_res.slot         = r_ent.vld ? r_slot : 16'd0;
        new_res.gate_out     = r_ent.vld ? r_ent.gate : 32'd0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        F_CLEAR: n_state = S_IDLE;
                        F_COUNT: n_state = in_rng ? S_CNT_DIV : S_IDLE;
                        F_PACK:  n_state = r_cur_ready ? S_STORE : S_CUR_RD;
                        F_QUERY: n_state = ({1'b0, i_node} < i_cfg.nodes) ? S_QRY_RD
                                                                           : S_QRY_OUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CNT_DIV: if (i_div_rsp.done) n_state = div_node_bad ? S_IDLE : S_CNT_WR;
            S_CNT_WR:  n_state = S_IDLE;
            S_QRY_RD:  n_state = S_QRY_ST;
            S_QRY_ST:  n_state = S_QRY_DIV;
            S_QRY_DIV: if (i_div_rsp.done) n_state = S_QRY_OUT;
            S_QRY_OUT: if (i_res_ready) n_state = S_IDLE;
            S_CUR_RD:  n_state = S_CUR_ST;
            S_CUR_ST:  n_state = S_CUR_DIV;
            S_CUR_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = (r_bkt == BKT_W'(MAX_BUCKETS - 1)) ? S_STORE : S_CUR_RD;
                end
            end
            S_STORE: begin
                if (elem_n >= i_cfg.row_len) begin
                    n_state = (i_cfg.row_len > 7'd1) ? S_SORT_RA : S_RUN_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SORT_RA:  n_state = S_SORT_GA;
            S_SORT_GA:  n_state = S_SORT_CHK;
            S_SORT_CHK: n_state = (r_b == '0) ? S_SORT_RA : S_SORT_CMP;
            S_SORT_CMP: n_state = sort_gt ? S_SORT_CHK : S_SORT_RA;
            S_RUN_CHK:  n_state = run_end ? S_DONE : S_RUN_LD;
            S_RUN_LD:   n_state = r_row_rd.vld ? S_RUN_DIV : S_RUN_CHK;
            S_RUN_DIV:  if (i_div_rsp.done) n_state = div_node_bad ? S_RUN_CHK : S_RUN_CUR;
            S_RUN_CUR:  n_state = cur_over ? S_RUN_CHK : S_MEM_CHK;
            S_MEM_CHK:  n_state = mem_end ? S_RUN_CHK : S_MEM_LD;
            S_MEM_LD:   n_state = r_row_rd.vld ? S_MEM_DIV : S_MEM_OUT;
            S_MEM_DIV:  if (i_div_rsp.done) n_state = S_MEM_OUT;
            S_MEM_OUT:  if (out_free) n_state = S_MEM_CHK;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
        // sort walk finished: move on to the runs
        if (sort_next && (a_n >= i_cfg.row_len)) n_state = S_RUN_CHK;
    end

    // memory ports, divider requests and result
    always_comb begin
        hist_we = 1'b0; hist_wa = r_bkt; hist_wd = hist_eff + 32'd1; hist_ra = r_bkt;
        cur_we  = 1'b0; cur_wa  = r_bkt; cur_wd  = r_base;            cur_ra  = r_bkt;
        row_we  = 1'b0; row_wa  = r_b;   row_wd  = r_ev;              row_ra  = r_b;
        o_div_req          = '0;
        o_div_req.divisor  = i_cfg.slots;
        o_div_req.dividend = r_row_rd.id;
        o_res_valid = 1'b0;
        o_res       = r_pend;
        case (r_state)
            S_IDLE: begin
                o_div_req.start    = in_acc && (i_func == F_COUNT) && in_rng;
                o_div_req.dividend = i_id;
            end
            S_CNT_DIV: hist_ra = i_div_rsp.quot[BKT_W-1:0];
            S_CNT_WR:  hist_we = 1'b1;
            S_QRY_RD:  hist_ra = r_node[BKT_W-1:0];
            S_QRY_ST, S_CUR_ST: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = hist_eff;
                o_div_req.divisor  = {10'd0, i_cfg.run_len};
                cur_we             = (r_state == S_CUR_ST);
            end
            S_QRY_OUT: begin
                o_res_valid       = 1'b1;
                o_res             = '0;
                o_res.kind        = K_COUNT;
                o_res.node_count  = r_cnt;
                o_res.last        = 1'b1;
            end
            S_STORE: begin
                row_we = !r_elem[6];
                row_wa = r_elem[ROW_AW-1:0];
                row_wd = '{vld: r_in_rng, gate: r_gate, id: r_id};
            end
            S_SORT_RA:  row_ra = r_a[ROW_AW-1:0];
            S_SORT_CHK: begin
                row_ra = r_b - ROW_AW'(1);
                row_we = (r_b == '0);
            end
            S_SORT_CMP: begin
                row_we = 1'b1;
                row_wd = sort_gt ? r_row_rd : r_ev;
            end
            S_RUN_CHK:  row_ra = r_lead[ROW_AW-1:0];
            S_RUN_LD, S_MEM_LD: o_div_req.start = r_row_rd.vld;
            S_RUN_DIV:  cur_ra = i_div_rsp.quot[BKT_W-1:0];
            S_RUN_CUR: begin
                cur_we = 1'b1;
                cur_wd = r_cur_rd + 32'd1;
            end
            S_MEM_CHK:  row_ra = mem_pos[ROW_AW-1:0];
            S_MEM_OUT:  o_res_valid = r_pend_v;
            S_DONE: begin
                o_res_valid = r_pend_v;
                o_res.last  = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist_mem[hist_wa] <= hist_wd;
        r_hist_rd <= r_hist_mem[hist_ra];
        if (cur_we) r_cur_mem[cur_wa] <= cur_wd;
        r_cur_rd <= r_cur_mem[cur_ra];
        if (row_we) r_row_mem[row_wa] <= row_wd;
        r_row_rd <= r_row_mem[row_ra];
    end

    // histogram entry valid bits, cleared at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (in_acc && (i_func == F_CLEAR)) begin
            r_hist_vld <= '0;
        end else if (hist_we) begin
            r_hist_vld[hist_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hist_rv <= r_hist_vld[hist_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elem      <= '0;
            r_tok       <= '0;
            r_cur_ready <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && (i_func == F_CLEAR)) begin
                r_elem      <= '0;
                r_tok       <= '0;
                r_cur_ready <= 1'b0;
            end
            if ((r_state == S_CUR_DIV) && i_div_rsp.done &&
                (r_bkt == BKT_W'(MAX_BUCKETS - 1))) begin
                r_cur_ready <= 1'b1;
            end
            if (r_state == S_STORE) begin
                r_elem <= (elem_n >= i_cfg.row_len) ? 7'd0 : elem_n;
            end
            if ((r_state == S_MEM_OUT) && out_free) r_pend_v <= 1'b1;
            if ((r_state == S_DONE) && out_free) begin
                r_pend_v <= 1'b0;
                r_tok    <= r_tok + 20'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id     <= i_id;
            r_gate   <= i_gate;
            r_node   <= i_node;
            r_in_rng <= in_rng;
            r_cnt    <= '0;
            r_bkt    <= '0;
            r_base   <= '0;
        end
        case (r_state)
            S_CNT_DIV: r_bkt <= i_div_rsp.quot[BKT_W-1:0];
            S_QRY_DIV: begin
                if (i_div_rsp.done) begin
                    r_cnt <= (i_div_rsp.quot > 32'h1F_FFFF) ? 21'h1F_FFFF
                                                            : i_div_rsp.quot[20:0];
                end
            end
            S_CUR_DIV: begin
                if (i_div_rsp.done) begin
                    r_base <= r_base + i_div_rsp.quot;
                    r_bkt  <= r_bkt + BKT_W'(1);
                end
            end
            S_STORE: begin
                r_a    <= 7'd1;
                r_j    <= '0;
                r_lead <= '0;
            end
            S_SORT_GA: begin
                r_ev <= r_row_rd;
                r_b  <= r_a[ROW_AW-1:0];
            end
            S_SORT_CMP: if (sort_gt) r_b <= r_b - ROW_AW'(1);
            S_RUN_DIV:  r_bkt <= i_div_rsp.quot[BKT_W-1:0];
            S_RUN_CUR: begin
                r_dst <= r_cur_rd;
                r_i   <= '0;
            end
            S_MEM_LD:  r_ent <= r_row_rd;
            S_MEM_DIV: r_slot <= i_div_rsp.rem[15:0];
            S_MEM_OUT: begin
                if (out_free) begin
                    r_pend <= new_res;
                    r_i    <= r_i + 7'd1;
                end
            end
            default: ;
        endcase
        if (sort_next) r_a <= a_n;
        if (run_adv) begin
            r_j    <= r_j + 7'd1;
            r_lead <= r_lead + {1'b0, i_cfg.run_len};
        end
    end

    `ASSERT_ON_CLK(a_cur_wr_ready, i_clk, i_rst_n,
        cur_we |-> (r_cur_ready || (r_state == S_CUR_ST)),
        "cursor written before cursor setup")
    `ASSERT_ON_CLK(a_store_after_setup, i_clk, i_rst_n,
        (r_state == S_STORE) |-> r_cur_ready,
        "row element stored before cursors were set")
    `ASSERT_NEXT(a_clear_effect, i_clk, i_rst_n,
        (in_acc && (i_func == F_CLEAR)),
        ((r_elem == 7'd0) && (r_tok == 20'd0) && !r_cur_ready && (r_hist_vld == '0)),
        "clear did not reset counters")

endmodule

// ===== src/moe_dispatch_bucket_packer_unit.sv =====
// Token dispatch packer for mixture-of-experts routing. Four operations arrive as
// words on the slave stream (clear, count an expert id, pack one element, query a
// node): count adds an id to a per-node histogram, pack collects the elements of a
// token row and, when the row is complete, sorts it by expert id and emits one
// word per member of each run whose leader is in range, with the send-buffer row
// taken from that node's cursor; query answers a node's run count. All divisions
// go through one shared restoring divider at one bit per cycle, and the row,
// histogram and cursor memories each have one registered read port. A count and
// a query each take one division. The first pack after reset or clear first sets
// the 256 cursors, one division each. A completing pack then sorts the row and
// takes one division per run leader and one per in-range member, and is held up
// further if the master side stalls. One output word may wait in the output
// register while the core keeps working.
module moe_dispatch_bucket_packer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [20:0]  i_cfg_data,
    // operation words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // expert_id[31:0], gate_bits[63:32], node_index[71:64]
    input  logic [1:0]   s_axis_tuser,  // func
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // dest_row[19:0], source_token[39:20],
                                        // member_index[45:40], slot[61:46],
                                        // gate_out[93:62], node_count[114:94], zero pad
    output logic         m_axis_tuser,  // kind
    output logic         m_axis_tlast
);
    import mdbp_pkg::*;

    logic [6:0]  r_epr, r_rlen, r_runs;
    logic [16:0] r_slots, r_elim;
    logic [8:0]  r_nodes;
    logic [20:0] r_rows;
    t_cfg        cfg;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_result     core_res, r_out;
    logic        core_res_v, core_res_rdy, r_out_v;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epr   <= 7'd1;
            r_rlen  <= 7'd1;
            r_runs  <= 7'd1;
            r_slots <= 17'd1;
            r_nodes <= 9'd1;
            r_elim  <= 17'd1;
            r_rows  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CI_ELEMS:   r_epr   <= i_cfg_data[6:0];
                CI_RUN_LEN: r_rlen  <= i_cfg_data[6:0];
                CI_RUNS:    r_runs  <= i_cfg_data[6:0];
                CI_SLOTS:   r_slots <= i_cfg_data[16:0];
                CI_NODES:   r_nodes <= i_cfg_data[8:0];
                CI_EXPERTS: r_elim  <= i_cfg_data[16:0];
                CI_ROWS:    r_rows  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // fold zero and overrange settings
    always_comb begin
        cfg.row_len = (r_epr == '0) ? 7'd1 :
                      (r_epr > 7'(MAX_ROW_ELEMENTS)) ? 7'(MAX_ROW_ELEMENTS) : r_epr;
        cfg.run_len = (r_rlen == '0) ? 7'd1 : r_rlen;
        cfg.runs    = r_runs;
        cfg.slots   = (r_slots == '0) ? 17'd1 : r_slots;
        cfg.nodes   = (r_nodes > 9'(MAX_BUCKETS)) ? 9'(MAX_BUCKETS) : r_nodes;
        cfg.elim    = r_elim;
        cfg.row_lim = (r_rows > 21'(MAX_ROWS)) ? 21'(MAX_ROWS) : r_rows;
    end

    mdbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mdbp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (t_func'(s_axis_tuser)),
        .i_id        (s_axis_tdata[31:0]),
        .i_gate      (s_axis_tdata[63:32]),
        .i_node      (s_axis_tdata[71:64]),
        .o_res_valid (core_res_v),
        .i_res_ready (core_res_rdy),
        .o_res       (core_res),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    // output register
    assign core_res_rdy = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (core_res_rdy) begin
            r_out_v <= core_res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_rdy && core_res_v) r_out <= core_res;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {5'd0, r_out.node_count, r_out.gate_out, r_out.slot,
                            r_out.member_index, r_out.source_token, r_out.dest_row};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

// ===== verif/tb_moe_dispatch_bucket_packer_unit.sv =====
`timescale 1ns / 100ps

import mdbp_pkg::*;

// Tracks the packer's histogram, cursors and row buffer; predicts the result words.
class packer_scoreboard;
    bit [6:0]  c_elems, c_run, c_runs;
    bit [16:0] c_slots, c_elim;
    bit [8:0]  c_nodes;
    bit [20:0] c_rowlim;
    bit [31:0] hist[MAX_BUCKETS];
    bit [31:0] cursor[MAX_BUCKETS];
    bit [31:0] ids[MAX_ROW_ELEMENTS];
    bit [31:0] gates[MAX_ROW_ELEMENTS];
    bit        vld[MAX_ROW_ELEMENTS];
    bit [6:0]  elem_cnt;
    bit [19:0] token;
    bit        cursors_set;
    t_result   expected_words[$];
    int        errors;

    function new();
        c_elems = 1; c_run = 1; c_runs = 1; c_slots = 1;
        c_nodes = 1; c_elim = 1; c_rowlim = 0;
        foreach (hist[b]) hist[b] = 0;
        elem_cnt = 0; token = 0; cursors_set = 0; errors = 0;
    endfunction

    function void set_reg(t_cfg_idx idx, bit [20:0] v);
        case (idx)
            CI_ELEMS:   c_elems  = v[6:0];
            CI_RUN_LEN: c_run    = v[6:0];
            CI_RUNS:    c_runs   = v[6:0];
            CI_SLOTS:   c_slots  = v[16:0];
            CI_NODES:   c_nodes  = v[8:0];
            CI_EXPERTS: c_elim   = v[16:0];
            CI_ROWS:    c_rowlim = v[20:0];
            default: ;
        endcase
    endfunction

    function bit id_ok(bit [31:0] id);
        return !id[31] && id < c_elim;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // one accepted operation word
    function void note_word(t_func f, bit [31:0] id, bit [31:0] gate, bit [7:0] node);
        int unsigned q, s, nodes_eff, len, lead, d, b, j, i, p;
        longint unsigned lim;
        bit [31:0] base, dst, ev, gv;
        bit ok;
        t_result r, words[$];
        q = (c_run == 0) ? 1 : c_run;
        s = (c_slots == 0) ? 1 : c_slots;
        nodes_eff = (c_nodes < MAX_BUCKETS) ? c_nodes : MAX_BUCKETS;
        len = (c_elems == 0) ? 1 : ((c_elems < MAX_ROW_ELEMENTS) ? c_elems : MAX_ROW_ELEMENTS);
        lim = (c_rowlim < MAX_ROWS) ? c_rowlim : MAX_ROWS;
        case (f)
            F_CLEAR: begin
                foreach (hist[k]) hist[k] = 0;
                elem_cnt = 0; token = 0; cursors_set = 0;
            end
            F_COUNT: begin
                if (id_ok(id) && id / s < nodes_eff) hist[id / s]++;
            end
            F_PACK: begin
                // cursors are prefix sums of run counts, fixed at the first pack
                if (!cursors_set) begin
                    base = 0;
                    for (b = 0; b < MAX_BUCKETS; b++) begin
                        cursor[b] = base;
                        base += hist[b] / q;
                    end
                    cursors_set = 1;
                end
                if (elem_cnt < MAX_ROW_ELEMENTS) begin
                    ids[elem_cnt] = id; gates[elem_cnt] = gate; vld[elem_cnt] = id_ok(id);
                end
                elem_cnt = elem_cnt + 1;
                if (elem_cnt >= len) begin
                    // stable insertion sort by raw id
                    for (i = 1; i < len; i++) begin
                        ev = ids[i]; gv = gates[i]; ok = vld[i]; p = i;
                        while (p > 0 && ids[p-1] > ev) begin
                            ids[p] = ids[p-1]; gates[p] = gates[p-1]; vld[p] = vld[p-1];
                            p--;
                        end
                        ids[p] = ev; gates[p] = gv; vld[p] = ok;
                    end
                    for (j = 0; j < c_runs; j++) begin
                        lead = j * q;
                        if (lead >= len) break;
                        if (!vld[lead]) continue;
                        d = ids[lead] / s;
                        if (d >= nodes_eff) continue;
                        dst = cursor[d];
                        cursor[d] = dst + 1;
                        if (dst >= lim) continue;
                        for (i = 0; i < q && lead + i < len; i++) begin
                            p = lead + i;
                            r = '0;
                            r.kind = K_MEMBER;
                            r.dest_row = dst[19:0];
                            r.source_token = token;
                            r.member_index = i[5:0];
                            r.slot = vld[p] ? 16'(ids[p] % s) : 16'd0;
                            r.gate_out = vld[p] ? gates[p] : 32'd0;
                            words.push_back(r);
                        end
                    end
                    token = token + 1;
                    elem_cnt = 0;
                end
            end
            default: begin
                r = '0;
                r.kind = K_COUNT;
                if (node < nodes_eff) begin
                    base = hist[node] / q;
                    r.node_count = (base > 32'h1FFFFF) ? 21'h1FFFFF : base[20:0];
                end
                words.push_back(r);
            end
        endcase
        if (words.size() > 0) words[words.size()-1].last = 1;
        foreach (words[k]) expected_words.push_back(words[k]);
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endfunction

    function void check_word(t_result got);
        t_result e;
        if (expected_words.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        e = expected_words.pop_front();
        cmp("kind", e.kind, got.kind);
        cmp("dest_row", e.dest_row, got.dest_row);
        cmp("source_token", e.source_token, got.source_token);
        cmp("member_index", e.member_index, got.member_index);
        cmp("slot", e.slot, got.slot);
        cmp("gate_out", e.gate_out, got.gate_out);
        cmp("node_count", e.node_count, got.node_count);
        cmp("last", e.last, got.last);
    endfunction
endclass

module tb_moe_dispatch_bucket_packer_unit;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [2:0]   i_cfg_idx = 0;
    logic [20:0]  i_cfg_data = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = 0;
    logic [1:0]   s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    packer_scoreboard sb = new();
    int  send_idle_pct = 7;
    int  recv_idle_pct = 76;
    bit  hold_req = 0;
    int  hold_left = 0;

    moe_dispatch_bucket_packer_unit u_top (.*);

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #(30_000_000);
        $display("tb_moe_dispatch_bucket_packer_unit: errors");
        $finish;
    end

    // result side: check accepted words, drive tready with idles and long holds
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind         = m_axis_tuser;
            got.dest_row     = m_axis_tdata[19:0];
            got.source_token = m_axis_tdata[39:20];
            got.member_index = m_axis_tdata[45:40];
            got.slot         = m_axis_tdata[61:46];
            got.gate_out     = m_axis_tdata[93:62];
            got.node_count   = m_axis_tdata[114:94];
            got.last         = m_axis_tlast;
            sb.check_word(got);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 3000;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_word(t_func f, bit [31:0] id, bit [31:0] gate, bit [7:0] node);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {node, gate, id};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(f, id, gate, node);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // drains results, lets trailing no-result work finish, then writes all registers
    task automatic write_config(bit [20:0] v[7]);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12000) @(posedge i_clk);
        for (int k = 0; k < 7; k++) begin
            i_cfg_we   <= 1;
            i_cfg_idx  <= k[2:0];
            i_cfg_data <= v[k];
            sb.set_reg(t_cfg_idx'(k), v[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic bit [31:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7 && sb.c_elim != 0) return $urandom_range(0, sb.c_elim - 1);
        if (r == 7) return $urandom;
        if (r == 8) return sb.c_elim + $urandom_range(0, 3);
        return 32'h80000000 | $urandom;
    endfunction

    // mostly counts and pack words, with queries and the odd clear
    task automatic random_phase(int n);
        int unsigned r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2) send_word(F_CLEAR, $urandom, $urandom, $urandom);
            else if (r < 32) send_word(F_COUNT, pick_id(), $urandom, $urandom);
            else if (r < 85) send_word(F_PACK, pick_id(), $urandom, $urandom);
            else send_word(F_QUERY, $urandom, $urandom,
                           $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                : $urandom_range(0, sb.c_nodes));
        end
    endtask

    // elems, run, runs, slots, nodes, experts, row limit
    bit [20:0] phase_cfg[7][7] = '{
        '{1, 1, 1, 1, 1, 1, 0},
        '{4, 2, 2, 4, 4, 40, 1048576},
        '{8, 1, 8, 2, 256, 600, 50},
        '{64, 64, 1, 65536, 256, 65536, 1048576},
        '{0, 0, 3, 0, 9, 20, 7},
        '{100, 3, 64, 5, 2, 65536, 1000},
        '{6, 1, 64, 100, 256, 65536, 1048576}
    };

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults after reset
        send_word(F_PACK, 0, 32'hFFFFFFFF, 0);
        send_word(F_QUERY, 0, 0, 0);

        for (int ph = 1; ph < 7; ph++) begin
            write_config(phase_cfg[ph]);
            if (ph == 3) begin
                send_idle_pct = 76; recv_idle_pct = 7;
            end else if (ph == 5) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            send_word(F_CLEAR, 0, 0, 0);
            if (ph == 1) begin
                // in range, limit edges, bad node, bit 31 set
                send_word(F_COUNT, 0, 0, 0);
                send_word(F_COUNT, 1, 0, 0);
                send_word(F_COUNT, 3, 0, 0);
                send_word(F_COUNT, 5, 0, 0);
                send_word(F_COUNT, 15, 0, 0);
                send_word(F_COUNT, 16, 0, 0);
                send_word(F_COUNT, 39, 0, 0);
                send_word(F_COUNT, 40, 0, 0);
                send_word(F_COUNT, 32'h80000000, 0, 0);
                send_word(F_COUNT, 32'hFFFFFFFF, 0, 0);
                send_word(F_QUERY, 0, 0, 0);
                send_word(F_QUERY, 0, 0, 3);
                send_word(F_QUERY, 0, 0, 4);
                send_word(F_QUERY, 0, 0, 8'hFF);
                send_word(F_PACK, 15, 32'hFFFFFFFF, 0);
                send_word(F_PACK, 0, 0, 0);
                send_word(F_PACK, 5, 32'h12345678, 0);
                send_word(F_PACK, 32'h80000003, 32'hFFFFFFFF, 0);
                send_word(F_PACK, 39, 1, 0);
                send_word(F_PACK, 1, 2, 0);
                send_word(F_PACK, 2, 3, 0);
                send_word(F_PACK, 3, 4, 0);
                send_word(F_COUNT, 1, 0, 0);
                send_word(F_QUERY, 0, 0, 0);
                hold_req = 1;
            end
            for (int k = 0; k < 12; k++) send_word(F_COUNT, pick_id(), 0, 0);
            random_phase(ph == 3 ? 150 : 60);
        end
        s_axis_tvalid <= 0;

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_moe_dispatch_bucket_packer_unit: clean");
        else
            $display("tb_moe_dispatch_bucket_packer_unit: errors");
        $finish;
    end

endmodule
